// ===== rtl/dpc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared constants, register codes and reset values for the depth pixel to
// camera point pipeline.
// ----------------------------------------------------------------------------
package dpc_pkg;

	// Fixed field widths.
	localparam int DIM_W     = 13;
	localparam int PIX_W     = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;
	localparam int FIX_W     = 32;

	// Default depth width and fixed-point format.
	localparam int DEPTH_BITS_DEF = 24;
	localparam int FRAC_BITS      = 16;
	localparam int MAX_DIM        = 4096;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 3'd0,
		CFG_FRAME_HEIGHT = 3'd1,
		CFG_FOCAL_LENGTH = 3'd2,
		CFG_NEAR_DIST    = 3'd3,
		CFG_DEPTH_SCALE  = 3'd4,
		CFG_LINEARIZE    = 3'd5
	} cfg_idx_t;

	// Register reset values.
	localparam logic [DIM_W-1:0] RST_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd480;
	localparam logic [31:0]      RST_FOCAL  = 32'd37879808;
	localparam logic [31:0]      RST_NEAR   = 32'd655;
	localparam logic [31:0]      RST_SCALE  = 32'd16760832;

endpackage

// ===== rtl/dpc_div_cell.sv =====
// ----------------------------------------------------------------------------
// dpc_div_cell
// One restoring division step: resolves a single quotient bit and hands the
// partial remainder, divisor and sideband to the next cell.
// ----------------------------------------------------------------------------
module dpc_div_cell #(
	parameter int RW  = 57,
	parameter int DW  = 25,
	parameter int QW  = 32,
	parameter int SW  = 1,
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          i_valid,
	input  logic [RW-1:0] i_rem,
	input  logic [DW-1:0] i_den,
	input  logic [QW-1:0] i_q,
	input  logic [SW-1:0] i_side,
	output logic          o_valid,
	output logic [RW-1:0] o_rem,
	output logic [DW-1:0] o_den,
	output logic [QW-1:0] o_q,
	output logic [SW-1:0] o_side
);

	logic [RW-1:0] trial;
	logic          ge;
	logic [QW-1:0] q_nxt;

	// Compare against the divisor aligned to this bit.
	always_comb begin
		trial      = RW'(i_den) << BIT;
		ge         = (i_rem >= trial);
		q_nxt      = i_q;
		q_nxt[BIT] = ge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid <= 1'b0;
		end else if (en) begin
			o_valid <= i_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_rem  <= ge ? (i_rem - trial) : i_rem;
			o_den  <= i_den;
			o_q    <= q_nxt;
			o_side <= i_side;
		end
	end

endmodule

// ===== rtl/dpc_div_chain.sv =====
// ----------------------------------------------------------------------------
// dpc_div_chain
// Row of division cells, one quotient bit per cell from the top bit down.
// The dividend must be below the divisor shifted by QW.
// ----------------------------------------------------------------------------
module dpc_div_chain #(
	parameter int RW = 57,
	parameter int DW = 25,
	parameter int QW = 32,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          i_valid,
	input  logic [RW-1:0] i_num,
	input  logic [DW-1:0] i_den,
	input  logic [SW-1:0] i_side,
	output logic          o_valid,
	output logic [QW-1:0] o_q,
	output logic [SW-1:0] o_side
);

	logic          v_c    [QW+1];
	logic [RW-1:0] rem_c  [QW+1];
	logic [DW-1:0] den_c  [QW+1];
	logic [QW-1:0] q_c    [QW+1];
	logic [SW-1:0] side_c [QW+1];

	// Chain entry.
	assign v_c[0]    = i_valid;
	assign rem_c[0]  = i_num;
	assign den_c[0]  = i_den;
	assign q_c[0]    = '0;
	assign side_c[0] = i_side;

	// Cells ordered from the most significant quotient bit.
	for (genvar k = 0; k < QW; k++) begin : g_cell
		dpc_div_cell #(
			.RW (RW),
			.DW (DW),
			.QW (QW),
			.SW (SW),
			.BIT(QW-1-k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.i_valid(v_c[k]),
			.i_rem  (rem_c[k]),
			.i_den  (den_c[k]),
			.i_q    (q_c[k]),
			.i_side (side_c[k]),
			.o_valid(v_c[k+1]),
			.o_rem  (rem_c[k+1]),
			.o_den  (den_c[k+1]),
			.o_q    (q_c[k+1]),
			.o_side (side_c[k+1])
		);
	end

	assign o_valid = v_c[QW];
	assign o_q     = q_c[QW];
	assign o_side  = side_c[QW];

endmodule

// ===== rtl/depth_pixel_to_camera_point.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_to_camera_point
// Converts a depth-buffer sample and its pixel position to a camera-frame
// point in Q16.16 through a pinhole model.
// ----------------------------------------------------------------------------
// Path from input transaction to result: two rows of 32 division cells in
// series (metric depth, then projection) plus six register stages.
// Throughput: one transaction per cycle; the pipeline holds only while a
// result waits at the output and the last stage is occupied.
// Reset clears all stage valid bits and loads the register defaults.
module depth_pixel_to_camera_point
	import dpc_pkg::*;
#(
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [DEPTH_BITS-1:0] depth_raw,
	input  logic [PIX_W-1:0]      pixel_col,
	input  logic [PIX_W-1:0]      pixel_row,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  point_valid,
	output logic signed [31:0]    point_x,
	output logic signed [31:0]    point_y,
	output logic [31:0]           point_z,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data
);

	localparam int D    = DEPTH_BITS;
	localparam int SH_R = (D >= FRAC_BITS) ? D - FRAC_BITS : 0;
	localparam int SH_L = (D >= FRAC_BITS) ? 0 : FRAC_BITS - D;
	localparam int RW1  = D + 33;
	localparam int DW1  = D + 1;
	localparam int SW1  = 33 + 2*PIX_W;
	localparam int MAG_W = 13;
	localparam int PRD_W = MAG_W + FIX_W;
	localparam int RW2  = 65;
	localparam int DW2  = 33;
	localparam int SWX  = 35;
	localparam int SWY  = 2;

	// Configuration registers.
	logic [DIM_W-1:0] width_q, height_q;
	logic [31:0]      focal_q, near_q;
	logic [D-1:0]     scale_q;
	logic             lin_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			focal_q  <= RST_FOCAL;
			near_q   <= RST_NEAR;
			scale_q  <= RST_SCALE[D-1:0];
			lin_q    <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				CFG_FRAME_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				CFG_FOCAL_LENGTH: focal_q  <= cfg_data;
				CFG_NEAR_DIST:    near_q   <= cfg_data;
				CFG_DEPTH_SCALE:  scale_q  <= cfg_data[D-1:0];
				CFG_LINEARIZE:    lin_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pipeline enable: moves unless a result waits and the last stage is full.
	logic en, last_valid, ld;
	assign ld       = !out_valid || !out_stall;
	assign en       = ld || !last_valid;
	assign in_stall = !en;

	// Stage 1: depth times scale, pass-through depth.
	logic             v_s1;
	logic [2*D-1:0]   prod_s1;
	logic [31:0]      zpt_s1;
	logic [PIX_W-1:0] u_s1, r_s1;
	logic [63:0]      d_ext;

	assign d_ext = 64'(depth_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (2*D)'(depth_raw) * (2*D)'(scale_q);
			zpt_s1  <= 32'((d_ext >> SH_R) << SH_L);
			u_s1    <= pixel_col;
			r_s1    <= pixel_row;
		end
	end

	// Stage 2: denominator, dividend and overflow check for metric depth.
	logic [D:0]     den2_c;
	logic [RW1-1:0] num_c;
	logic           ovf_c, use_q_c;
	logic [31:0]    alt_c;
	logic           v_s2;
	logic [RW1-1:0] num_s2;
	logic [DW1-1:0] den_s2;
	logic [SW1-1:0] side_s2;

	always_comb begin
		den2_c  = {1'b1, {D{1'b0}}} - {1'b0, prod_s1[2*D-1:D]};
		num_c   = RW1'(near_q) << D;
		ovf_c   = (num_c >= (RW1'(den2_c) << 32));
		use_q_c = lin_q && !ovf_c && (den2_c != '0);
		if (!lin_q) begin
			alt_c = zpt_s1;
		end else if (den2_c == '0) begin
			alt_c = '0;
		end else begin
			alt_c = '1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2  <= use_q_c ? num_c : '0;
			den_s2  <= (den2_c == '0) ? DW1'(1) : den2_c;
			side_s2 <= {use_q_c, alt_c, u_s1, r_s1};
		end
	end

	// Metric depth division row.
	logic           v_d1;
	logic [31:0]    q_d1;
	logic [SW1-1:0] side_d1;

	dpc_div_chain #(.RW(RW1), .DW(DW1), .QW(32), .SW(SW1)) u_zdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.i_valid(v_s2),
		.i_num  (num_s2),
		.i_den  (den_s2),
		.i_side (side_s2),
		.o_valid(v_d1),
		.o_q    (q_d1),
		.o_side (side_d1)
	);

	// Stage 3: select depth, center the pixel about the principal point.
	logic [31:0]      z_c;
	logic [DIM_W-1:0] wc_c, hc_c;
	logic [14:0]      cx_c, cy_c;
	logic             v_s3, zv_s3, negx_s3, negy_s3;
	logic [31:0]      z_s3;
	logic [MAG_W-1:0] magx_s3, magy_s3;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] dim);
		logic [DIM_W-1:0] r;
		if (dim == '0) begin
			r = DIM_W'(1);
		end else if (32'(dim) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = dim;
		end
		return r;
	endfunction

	always_comb begin
		z_c  = side_d1[SW1-1] ? q_d1 : side_d1[SW1-2 -: 32];
		wc_c = clamp_dim(width_q) - DIM_W'(1);
		hc_c = clamp_dim(height_q) - DIM_W'(1);
		cx_c = {2'b00, side_d1[2*PIX_W-1:PIX_W], 1'b0} - {2'b00, wc_c};
		cy_c = {2'b00, side_d1[PIX_W-1:0], 1'b0} - {2'b00, hc_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s3    <= z_c;
			zv_s3   <= (z_c != '0);
			negx_s3 <= cx_c[14];
			negy_s3 <= cy_c[14];
			magx_s3 <= cx_c[14] ? MAG_W'(-cx_c) : cx_c[MAG_W-1:0];
			magy_s3 <= cy_c[14] ? MAG_W'(-cy_c) : cy_c[MAG_W-1:0];
		end
	end

	// Stage 4: offset times depth.
	logic             v_s4, zv_s4, negx_s4, negy_s4;
	logic [31:0]      z_s4;
	logic [PRD_W-1:0] px_s4, py_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s4    <= z_s3;
			zv_s4   <= zv_s3;
			negx_s4 <= negx_s3;
			negy_s4 <= negy_s3;
			px_s4   <= PRD_W'(magx_s3) * PRD_W'(z_s3);
			py_s4   <= PRD_W'(magy_s3) * PRD_W'(z_s3);
		end
	end

	// Stage 5: twice the focal length and quotient overflow checks.
	logic [DW2-1:0] fd_c;
	logic [RW2-1:0] lim_c;
	logic           ovfx_c, ovfy_c;
	logic           v_s5;
	logic [RW2-1:0] px_s5, py_s5;
	logic [DW2-1:0] fd_s5;
	logic [SWX-1:0] sx_s5;
	logic [SWY-1:0] sy_s5;

	always_comb begin
		fd_c   = {((focal_q == '0) ? 32'd1 : focal_q), 1'b0};
		lim_c  = RW2'(fd_c) << 32;
		ovfx_c = (RW2'(px_s4) >= lim_c);
		ovfy_c = (RW2'(py_s4) >= lim_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s5 <= ovfx_c ? '0 : RW2'(px_s4);
			py_s5 <= ovfy_c ? '0 : RW2'(py_s4);
			fd_s5 <= fd_c;
			sx_s5 <= {zv_s4, z_s4, negx_s4, ovfx_c};
			sy_s5 <= {negy_s4, ovfy_c};
		end
	end

	// Projection division rows, one per axis.
	logic           v_dx, v_dy;
	logic [31:0]    qx, qy;
	logic [SWX-1:0] sx;
	logic [SWY-1:0] sy;

	dpc_div_chain #(.RW(RW2), .DW(DW2), .QW(32), .SW(SWX)) u_xdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.i_valid(v_s5),
		.i_num  (px_s5),
		.i_den  (fd_s5),
		.i_side (sx_s5),
		.o_valid(v_dx),
		.o_q    (qx),
		.o_side (sx)
	);

	dpc_div_chain #(.RW(RW2), .DW(DW2), .QW(32), .SW(SWY)) u_ydiv (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.i_valid(v_s5),
		.i_num  (py_s5),
		.i_den  (fd_s5),
		.i_side (sy_s5),
		.o_valid(v_dy),
		.o_q    (qy),
		.o_side (sy)
	);

	assign last_valid = v_dx;

	// Sign and saturate a projected coordinate.
	function automatic logic [31:0] sat_coord(input logic neg, input logic ovf,
			input logic [31:0] q);
		logic [31:0] r;
		if (neg) begin
			r = (ovf || q[31]) ? 32'h8000_0000 : (32'd0 - q);
		end else begin
			r = (ovf || q[31]) ? 32'h7FFF_FFFF : q;
		end
		return r;
	endfunction

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ld) begin
			out_valid <= last_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			point_valid <= sx[SWX-1];
			point_z     <= sx[SWX-1] ? sx[SWX-2 -: 32] : '0;
			point_x     <= sx[SWX-1] ? sat_coord(sx[1], sx[0], qx) : '0;
			point_y     <= sx[SWX-1] ? sat_coord(sy[1], sy[0], qy) : '0;
		end
	end

	// Both axis rows advance in lockstep.
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		v_dx == v_dy) else $error("axis division rows out of step");

	// A waiting result with a full last stage must hold the input side.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && last_valid |-> in_stall)
		else $error("pipeline would overrun a waiting result");

	// An invalid point carries all-zero fields.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> point_x == 0 && point_y == 0 && point_z == 0)
		else $error("invalid point with nonzero fields");

	// A valid point has a positive depth.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && point_valid |-> point_z != 0)
		else $error("valid point with zero depth");

endmodule

// ===== bench/depth_pixel_to_camera_point_checker.sv =====
// ----------------------------------------------------------------------------
// Depth pixel to camera point checker
// Watches the register, input and output channels of the block. It predicts
// the camera-frame point for every accepted input transaction from its own
// copy of the registers. Each accepted output transaction is compared with
// the oldest predicted point.
// ----------------------------------------------------------------------------
module depth_pixel_to_camera_point_checker
	import dpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [23:0]          depth_raw,
	input  logic [PIX_W-1:0]     pixel_col,
	input  logic [PIX_W-1:0]     pixel_row,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 point_valid,
	input  logic signed [31:0]   point_x,
	input  logic signed [31:0]   point_y,
	input  logic [31:0]          point_z,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output int                   fail_count,
	output int                   pending_points
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        valid;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} cam_point_t;

	cam_point_t point_queue[$];

	logic [12:0] width_reg, height_reg;
	logic [31:0] focal_reg, near_reg;
	logic [23:0] scale_reg;
	logic        lin_reg;

	// Depth in meters, Q16.16, from the normalized buffer value.
	function automatic logic [31:0] depth_meters(logic [23:0] d);
		logic [63:0] prod, den, quo;
		if (lin_reg) begin
			prod = 64'(d) * 64'(scale_reg);
			den = (64'd1 << 24) - (prod >> 24);
			if (den == 0)
				return 32'd0;
			quo = (64'(near_reg) << 24) / den;
			return (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
		end
		return 32'(d >> 8);
	endfunction

	// One axis of the pinhole back-projection, truncated toward zero.
	function automatic logic [31:0] project_axis(logic [11:0] idx, logic [12:0] dim_in,
		logic [31:0] z);
		logic [12:0] dim;
		longint c2;
		logic [63:0] mag, den, quo;
		dim = (dim_in < 1) ? 13'd1 : (dim_in > MAX_DIM) ? 13'(MAX_DIM) : dim_in;
		c2 = 2 * longint'(idx) - (longint'(dim) - 1);
		mag = (c2 < 0) ? 64'(-c2) : 64'(c2);
		den = 2 * ((focal_reg == 0) ? 64'd1 : 64'(focal_reg));
		quo = (mag * 64'(z)) / den;
		if (c2 < 0)
			return (quo >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-quo);
		return (quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
	endfunction

	// Track registers, predict on input, compare on output.
	always @(posedge clk or negedge arst_n) begin
		cam_point_t exp_pt;
		logic [31:0] z;
		if (!arst_n) begin
			width_reg <= RST_WIDTH;
			height_reg <= RST_HEIGHT;
			focal_reg <= RST_FOCAL;
			near_reg <= RST_NEAR;
			scale_reg <= RST_SCALE[23:0];
			lin_reg <= 1'b1;
			fail_count <= 0;
			point_queue.delete();
			pending_points <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_FRAME_WIDTH:  width_reg <= cfg_data[12:0];
					CFG_FRAME_HEIGHT: height_reg <= cfg_data[12:0];
					CFG_FOCAL_LENGTH: focal_reg <= cfg_data;
					CFG_NEAR_DIST:    near_reg <= cfg_data;
					CFG_DEPTH_SCALE:  scale_reg <= cfg_data[23:0];
					CFG_LINEARIZE:    lin_reg <= cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				z = depth_meters(depth_raw);
				if (z == 0)
					exp_pt = '0;
				else
					exp_pt = '{1'b1, project_axis(pixel_col, width_reg, z),
						project_axis(pixel_row, height_reg, z), z};
				point_queue.insert(point_queue.size(), exp_pt);
			end
			if (out_valid && !out_stall) begin
				if (point_queue.size() == 0) begin
					$error("unexpected output transaction");
					fail_count <= fail_count + 1;
				end else begin
					exp_pt = point_queue.pop_front();
					if (point_valid !== exp_pt.valid || point_x !== exp_pt.x ||
						point_y !== exp_pt.y || point_z !== exp_pt.z) begin
						fail_count <= fail_count + 1;
						if (point_valid !== exp_pt.valid)
							$error("point_valid expected %0d actual %0d", exp_pt.valid,
								point_valid);
						if (point_x !== exp_pt.x)
							$error("point_x expected %0d actual %0d",
								$signed(exp_pt.x), point_x);
						if (point_y !== exp_pt.y)
							$error("point_y expected %0d actual %0d",
								$signed(exp_pt.y), point_y);
						if (point_z !== exp_pt.z)
							$error("point_z expected %0d actual %0d", exp_pt.z, point_z);
					end
				end
			end
			pending_points <= point_queue.size();
		end
	end

endmodule

// ===== bench/depth_pixel_to_camera_point_tb.sv =====
// ----------------------------------------------------------------------------
// Depth pixel to camera point testbench
// Drives directed and random depth samples through several register settings
// with bursty input and random output stalls, including long output
// hold-offs, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module depth_pixel_to_camera_point_tb;
	import dpc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 70;
	localparam int IDLE_LIMIT = 20000;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [23:0] depth_raw;
	logic [PIX_W-1:0] pixel_col, pixel_row;
	logic point_valid;
	logic signed [31:0] point_x, point_y;
	logic [31:0] point_z;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	int fail_count, pending_points;
	int idle_cycles;
	bit hold_off_req;

	depth_pixel_to_camera_point dut (.*);

	depth_pixel_to_camera_point_checker checker_inst (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver stall pattern, with a long hold-off when requested.
	initial begin
		int mode, hold;
		out_stall = 1'b0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				for (hold = 0; hold < 400; hold++)
					@(negedge clk);
			end
			if ($urandom_range(0, 63) == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 1) == 0);
				default: out_stall <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Watchdog on cycles without any accepted transaction.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
			|| !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Offer one register write and wait until it is taken; valid stays high.
	task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_setting(logic [12:0] w, logic [12:0] h, logic [31:0] f,
		logic [31:0] nr, logic [23:0] sc, logic lin);
		write_reg(CFG_FRAME_WIDTH, 32'(w));
		write_reg(CFG_FRAME_HEIGHT, 32'(h));
		write_reg(CFG_FOCAL_LENGTH, f);
		write_reg(CFG_NEAR_DIST, nr);
		write_reg(CFG_DEPTH_SCALE, 32'(sc));
		write_reg(CFG_LINEARIZE, 32'(lin));
		cfg_valid <= 1'b0;
	endtask

	// Offer one sample and hold it until accepted, then maybe leave a gap.
	task automatic send_sample(logic [23:0] d, logic [11:0] u, logic [11:0] v, bit gap);
		int g;
		in_valid <= 1'b1;
		depth_raw <= d;
		pixel_col <= u;
		pixel_row <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		if (gap) begin
			in_valid <= 1'b0;
			for (g = $urandom_range(1, 6); g > 0; g--)
				@(negedge clk);
		end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_points != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	function automatic logic [23:0] rand_depth();
		case ($urandom_range(0, 5))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2: return 24'($urandom_range(0, 255));
			3: return 24'hFFFFFF - 24'($urandom_range(0, 4095));
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic random_phase(int count);
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0)
				burst = $urandom_range(1, 40);
			burst--;
			send_sample(rand_depth(), 12'($urandom), 12'($urandom), burst == 0);
			if (i == count / 2 && $urandom_range(0, 1) == 0)
				hold_off_req = 1'b1;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		depth_raw = '0;
		pixel_col = '0;
		pixel_row = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data = '0;
		hold_off_req = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: field extremes with reset registers, then corner settings.
		send_sample(24'd0, 12'd0, 12'd0, 1'b0);
		send_sample(24'hFFFFFF, 12'd4095, 12'd4095, 1'b0);
		send_sample(24'h800000, 12'd319, 12'd240, 1'b1);
		send_sample(24'd1, 12'd639, 12'd479, 1'b0);
		send_sample(24'hFFFFFE, 12'd0, 12'd4095, 1'b0);
		drain();
		// Near distance zero, focal zero, frame size zero.
		load_setting(13'd0, 13'd0, 32'd0, 32'd0, 24'd0, 1'b1);
		send_sample(24'hFFFFFF, 12'd5, 12'd7, 1'b0);
		drain();
		// Huge near and full scale saturate z and the projection.
		load_setting(13'h1FFF, 13'd4096, 32'd0, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1);
		send_sample(24'hFFFFFF, 12'd0, 12'd4095, 1'b0);
		send_sample(24'd0, 12'd4095, 12'd0, 1'b0);
		send_sample(24'h000001, 12'd2048, 12'd2047, 1'b0);
		drain();
		// Pass-through with small fractions that truncate to zero.
		load_setting(13'd1, 13'd1, 32'hFFFFFFFF, 32'd0, 24'd0, 1'b0);
		send_sample(24'h0000FF, 12'd0, 12'd0, 1'b0);
		send_sample(24'h000100, 12'd0, 12'd0, 1'b0);
		send_sample(24'hFFFFFF, 12'd4095, 12'd4095, 1'b0);
		drain();
		load_setting(13'd2, 13'd3, 32'd1, 32'd65536, 24'd8388608, 1'b0);
		send_sample(24'hFFFFFF, 12'd4095, 12'd0, 1'b0);
		send_sample(24'h123456, 12'd1, 12'd1, 1'b0);
		drain();

		// Random phases through several settings.
		load_setting(RST_WIDTH, RST_HEIGHT, RST_FOCAL, RST_NEAR, RST_SCALE[23:0], 1'b1);
		random_phase(300);
		hold_off_req = 1'b1;
		random_phase(300);
		drain();
		for (int p = 0; p < 3; p++) begin
			load_setting(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
				$urandom_range(0, 3) == 0 ? 32'($urandom) : 32'($urandom_range(1 << 16, 1 << 26)),
				$urandom_range(0, 3) == 0 ? 32'($urandom) : 32'($urandom_range(0, 1 << 20)),
				24'($urandom), 1'($urandom));
			random_phase(300);
			drain();
		end

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/dpc_pkg.sv
rtl/dpc_div_cell.sv
rtl/dpc_div_chain.sv
rtl/depth_pixel_to_camera_point.sv
bench/depth_pixel_to_camera_point_checker.sv
bench/depth_pixel_to_camera_point_tb.sv
